// ===== sv/kmh_pkg.sv =====
`default_nettype none

package kmh_pkg;

    localparam int KMER_LEN    = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int WIN_BITS    = 2 * KMER_LEN;
    localparam int NUM_BINS    = 1 << WIN_BITS;
    localparam int FILL_W      = $clog2(KMER_LEN + 1);
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 12;
    localparam int OUT_CNT_W   = 16;

    typedef logic [WIN_BITS-1:0]    win_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic valid;
        logic [1:0] code;
    } base_t;

    // command from the front end to the histogram store
    typedef struct packed {
        logic inc_en;
        logic rd_en;
        win_t addr;
        logic clr_en;
        win_t clr_addr;
    } hist_cmd_t;

    function automatic base_t base_code(input logic [CHAR_W-1:0] ch);
        base_t b;
        b.valid = 1'b1;
        case (ch)
            "A", "a": b.code = 2'd0;
            "C", "c": b.code = 2'd1;
            "G", "g": b.code = 2'd2;
            "T", "t": b.code = 2'd3;
            default:
            begin
                b.valid = 1'b0;
                b.code  = 2'd0;
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/kmh_hist.sv =====
`default_nettype none

module kmh_hist (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire kmh_pkg::hist_cmd_t cmd,
    output kmh_pkg::count_t     rd_count
);
    import kmh_pkg::*;

    count_t mem [NUM_BINS];
    count_t mem_q_reg;

    logic   s1_inc_reg;
    win_t   s1_addr_reg;

    // last write, for the read issued in the same cycle as that write
    logic   lw_valid_reg;
    win_t   lw_addr_reg;
    count_t lw_data_reg;

    count_t cur;
    count_t inc_val;
    logic   wr_en;
    win_t   wr_addr;
    count_t wr_data;

    assign cur     = (lw_valid_reg && lw_addr_reg == s1_addr_reg) ? lw_data_reg : mem_q_reg;
    assign inc_val = (cur == '1) ? cur : cur + count_t'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = inc_val;
        if (cmd.clr_en)
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.clr_addr;
            wr_data = '0;
        end
        else if (s1_inc_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en || cmd.inc_en)
        begin
            mem_q_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_inc_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_inc_reg   <= cmd.inc_en;
            lw_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= cmd.addr;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
    end

    assign rd_count = cur;

endmodule

`default_nettype wire

// ===== sv/kmer_histogram_k6_top.sv =====
`default_nettype none
// channel   valid      stall      payload
// request   req_valid  req_stall  req_type, base_char, bin_index
// result    rsp_valid  rsp_stall  bin_count, bin_number
// config    cfg_we     -          cfg_wdata
//
// one request per cycle while req_stall is low; a push or read enters the histogram ram at once,
// and its read-modify-write finishes the next cycle with forwarding of the last write.
// a read result is held in the ram output register, then written into the output queue,
// from which it is offered.
// reset and every new-read request start a clearing sweep over all 4096 bins,
// one bin a cycle, with req_stall high; config writes are taken throughout.
// a two-entry output queue lets requests flow while a result waits.

module kmer_histogram_k6_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire  [1:0]                   req_type,
    input  wire  [kmh_pkg::CHAR_W-1:0]   base_char,
    input  wire  [kmh_pkg::IDX_W-1:0]    bin_index,
    output logic                         rsp_valid,
    input  wire                          rsp_stall,
    output logic [kmh_pkg::OUT_CNT_W-1:0] bin_count,
    output logic [kmh_pkg::IDX_W-1:0]    bin_number,
    input  wire                          cfg_we,
    input  wire                          cfg_wdata
);
    import kmh_pkg::*;

    state_t state_reg, state_next;
    win_t   clr_cnt_reg, clr_cnt_next;
    win_t   window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic   rc_mode_reg;

    logic   s1_read_reg;
    logic [IDX_W-1:0] s1_num_reg;

    count_t           q_cnt_reg [2];
    logic [IDX_W-1:0] q_num_reg [2];
    logic             head_reg;
    logic [1:0]       used_reg;

    req_t      kind;
    logic      accept;
    logic      pop;
    logic [2:0] occ;
    base_t     b;
    logic [1:0] ins;
    win_t      win_push;
    logic [FILL_W-1:0] fill_push;
    hist_cmd_t cmd;
    count_t    rd_count;
    logic      tail;

    kmh_hist u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_count (rd_count)
    );

    assign kind   = req_t'(req_type);
    assign pop    = rsp_valid && !rsp_stall;
    assign occ    = 3'(used_reg) + 3'(s1_read_reg) - 3'(pop);
    assign accept = req_valid && !req_stall;
    assign tail   = head_reg ^ used_reg[0];

    always_comb
    begin
        req_stall = (state_reg == ST_CLEAR) || (kind == REQ_READ && occ >= 3'd2);
    end

    // window update for a push
    always_comb
    begin
        b = base_code(base_char);
        if (rc_mode_reg)
        begin
            ins      = b.valid ? ~b.code : 2'd0;
            win_push = (window_reg >> 2) | (win_t'(ins) << (WIN_BITS - 2));
        end
        else
        begin
            ins      = b.code;
            win_push = (window_reg << 2) | win_t'(ins);
        end
        fill_push = (fill_reg < FILL_W'(KMER_LEN)) ? fill_reg + FILL_W'(1) : fill_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        cmd.inc_en   = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.addr     = win_push;
        cmd.clr_en   = 1'b0;
        cmd.clr_addr = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + win_t'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    case (kind)
                        REQ_PUSH:
                        begin
                            window_next = win_push;
                            fill_next   = fill_push;
                            cmd.inc_en  = (fill_push == FILL_W'(KMER_LEN));
                        end
                        REQ_READ:
                        begin
                            cmd.rd_en = 1'b1;
                            cmd.addr  = win_t'(bin_index);
                        end
                        REQ_CLEAR:
                        begin
                            window_next  = '0;
                            fill_next    = '0;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            // unused code, no effect
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            window_reg  <= '0;
            fill_reg    <= '0;
            rc_mode_reg <= 1'b0;
            s1_read_reg <= 1'b0;
            head_reg    <= 1'b0;
            used_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            if (cfg_we)
            begin
                rc_mode_reg <= cfg_wdata;
            end
            s1_read_reg <= cmd.rd_en;
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
            used_reg <= 2'(occ);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_num_reg <= bin_index;
        if (s1_read_reg)
        begin
            q_cnt_reg[tail] <= rd_count;
            q_num_reg[tail] <= s1_num_reg;
        end
    end

    assign rsp_valid  = (used_reg != 2'd0);
    assign bin_count  = OUT_CNT_W'(q_cnt_reg[head_reg]);
    assign bin_number = q_num_reg[head_reg];

endmodule

`default_nettype wire

// ===== test/tb_kmer_histogram_k6_top.sv =====
module tb_kmer_histogram_k6_top;

    import kmh_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         SAT_PUSHES   = 60;
    localparam int         SETTLE_TICKS = 8;
    localparam int         PHASE_REQS   = 180;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] cnt;
        logic [IDX_W-1:0]     num;
    } bin_result_t;

    // mirror of the k-mer window and histogram, plus the queue of bin reads in flight
    class kmer_scoreboard;
        logic [WIN_BITS-1:0]    window;
        int unsigned            filled;
        logic [COUNT_WIDTH-1:0] counts [NUM_BINS];
        bit                     rc_mode;
        bin_result_t            pending [$];
        int                     failures;

        function new();
            clear_read();
            rc_mode  = 1'b0;
            failures = 0;
        endfunction

        function void clear_read();
            window = '0;
            filled = 0;
            foreach (counts[i])
                counts[i] = '0;
        endfunction

        function void set_mode(bit m);
            rc_mode = m;
        endfunction

        function void push_base(logic [CHAR_W-1:0] ch);
            logic [1:0] code;
            logic [1:0] ins;
            bit         known;
            known = 1'b1;
            case (ch)
                "A", "a": code = 2'd0;
                "C", "c": code = 2'd1;
                "G", "g": code = 2'd2;
                "T", "t": code = 2'd3;
                default:
                begin
                    known = 1'b0;
                    code  = 2'd0;
                end
            endcase
            if (rc_mode)
            begin
                // a non-base goes in as A on the reverse strand too
                ins    = known ? 2'd3 - code : 2'd0;
                window = {ins, window[WIN_BITS-1:2]};
            end
            else
                window = {window[WIN_BITS-3:0], code};
            if (filled < KMER_LEN)
                filled++;
            if (filled >= KMER_LEN && counts[window] != '1)
                counts[window]++;
        endfunction

        function void note_request(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                                   logic [IDX_W-1:0] idx);
            bin_result_t r;
            case (kind)
                REQ_PUSH: push_base(ch);
                REQ_READ:
                begin
                    r.cnt = counts[idx % NUM_BINS];
                    r.num = idx;
                    pending.insert(pending.size(), r);
                end
                REQ_CLEAR: clear_read();
                default: ;
            endcase
        endfunction

        function void report(string what, bin_result_t want, bin_result_t got);
            failures++;
            if (failures <= 10)
                $display({"bin result error (%s): expected count %0d bin %0d,",
                          " got count %0d bin %0d"},
                         what, want.cnt, want.num, got.cnt, got.num);
        endfunction

        function void check_result(logic [OUT_CNT_W-1:0] cnt, logic [IDX_W-1:0] num);
            bin_result_t got;
            bin_result_t want;
            got.cnt = cnt;
            got.num = num;
            if (pending.size() == 0)
            begin
                report("nothing outstanding", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.cnt !== want.cnt || got.num !== want.num)
                report("field", want, got);
        endfunction
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 req_valid  = 1'b0;
    logic                 req_stall;
    logic [1:0]           req_type   = REQ_PUSH;
    logic [CHAR_W-1:0]    base_char  = '0;
    logic [IDX_W-1:0]     bin_index  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall  = 1'b0;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [IDX_W-1:0]     bin_number;
    logic                 cfg_we     = 1'b0;
    logic                 cfg_wdata  = 1'b0;

    kmer_scoreboard sb;
    bit             no_idle = 1'b0;
    int unsigned    cycles  = 0;

    kmer_histogram_k6_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .base_char  (base_char),
        .bin_index  (bin_index),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .bin_count  (bin_count),
        .bin_number (bin_number),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 17);
    endfunction

    always @(negedge clk)
        rsp_stall = idle_now();

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kmer_histogram_k6_top: mismatch");
            $finish;
        end
        else if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(bin_count, bin_number);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        while (idle_now())
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_type  = kind;
        base_char = ch;
        bin_index = idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(kind, ch, idx);
        @(negedge clk);
    endtask

    // hold off until every bin read has come back, then let the pipeline settle
    task automatic settle();
        req_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_mode(bit m);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_mode(m);
    endtask

    task automatic random_phase(int n);
        int                r;
        string             bases;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        bases = "ACGTacgt";
        for (int i = 0; i < n; i++)
        begin
            r   = $urandom_range(0, 99);
            ch  = $urandom_range(0, 255);
            idx = $urandom_range(0, NUM_BINS - 1);
            if (r < 2)
                send(REQ_CLEAR, ch, idx);
            else if (r < 4)
                send(REQ_UNUSED, ch, idx);
            else if (r < 60)
            begin
                if ($urandom_range(0, 9) != 0)
                    ch = bases[$urandom_range(0, 7)];
                send(REQ_PUSH, ch, idx);
            end
            else
            begin
                // reading the live window bin exercises the write forwarding
                if ($urandom_range(0, 1) != 0)
                    idx = sb.window;
                send(REQ_READ, ch, idx);
            end
        end
    endtask

    initial
    begin
        string fwd_read;
        string rc_read;
        fwd_read = "AcGtCa";
        rc_read  = "gTNaCt";
        sb = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_mode(1'b0);

        // forward strand: empty histogram, mixed case, non-bases, unused code, clear
        send(REQ_READ, 8'h00, 12'h000);
        send(REQ_READ, 8'hFF, 12'hFFF);
        for (int i = 0; i < 6; i++)
            send(REQ_PUSH, fwd_read[i], 12'h000);
        send(REQ_READ, 8'h00, sb.window);
        send(REQ_PUSH, 8'h00, 12'h000);
        send(REQ_PUSH, 8'hFF, 12'hFFF);
        send(REQ_READ, 8'h00, sb.window);
        send(REQ_UNUSED, "T", 12'hFFF);
        send(REQ_CLEAR, 8'hFF, 12'hFFF);
        send(REQ_READ, 8'h00, 12'h1B4);

        // reverse strand, then a long back-to-back run on one bin
        write_mode(1'b1);
        for (int i = 0; i < 6; i++)
            send(REQ_PUSH, rc_read[i], $urandom_range(0, NUM_BINS - 1));
        send(REQ_READ, 8'h00, sb.window);
        send(REQ_READ, 8'h00, 12'h555);
        no_idle = 1'b1;
        repeat (SAT_PUSHES) send(REQ_PUSH, "a", $urandom_range(0, NUM_BINS - 1));
        send(REQ_READ, 8'h00, 12'hFFF);
        send(REQ_READ, 8'h00, 12'h000);
        no_idle = 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            write_mode(p[0]);
            no_idle = (p == 2);
            random_phase(PHASE_REQS);
        end
        no_idle = 1'b0;

        settle();
        if (sb.pending.size() != 0)
            sb.failures += sb.pending.size();
        if (sb.failures == 0)
            $display("kmer_histogram_k6_top: match");
        else
            $display("kmer_histogram_k6_top: mismatch");
        $finish;
    end

endmodule
